### rtl/core/wqg_pkg.sv
`timescale 1ns / 1ps
// wqg_pkg: shared constants, command word and codes of the work queue gather scheduler
// no dependencies

package wqg_pkg;

  localparam int NUM_QUEUES  = 32;
  localparam int QIDX_BITS   = 5;
  localparam int PTR_BITS    = 16;
  localparam int SLOT_BITS   = 16;
  localparam int SIZE_BITS   = 17;
  localparam int ADDR_BITS   = 32;
  localparam int OFS_BITS    = 17;
  localparam int BATCH_MAX   = 4;
  localparam int CNT_BITS    = 3;
  localparam int WRAP_SPAN   = 32;
  localparam int WRAP_BITS   = $clog2(WRAP_SPAN);
  localparam int ROOM_BITS   = WRAP_BITS + 1;
  localparam int ENTRY_SHIFT = 4;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_BITS = 1;
  localparam int CMDQ_CNT_BITS = 2;

  typedef enum logic [1:0] {
    ST_DISPATCH = 2'd0,
    ST_NO_QUEUE = 2'd1,
    ST_NO_WORK  = 2'd2,
    ST_STORED   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_GATHER = 1'b1
  } cmd_kind_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } back_state_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [QIDX_BITS-1:0]   queue;
    logic [PTR_BITS-1:0]    write_ptr;
    logic                   shut;
    logic [PTR_BITS-1:0]    ptr_mask;
    logic [ADDR_BITS-1:0]   base_lo;
    logic [ADDR_BITS-1:0]   base_hi;
  } cmd_t;

endpackage

### rtl/core/wqg_front.sv
`timescale 1ns / 1ps
// wqg_front: input stage, classifies each word and builds the command word
// depends on wqg_pkg

module wqg_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [wqg_pkg::QIDX_BITS-1:0]     queue_index,
  input  logic [wqg_pkg::PTR_BITS-1:0]      write_pointer,
  input  logic                              shut_down,
  input  logic [wqg_pkg::SIZE_BITS-1:0]     queue_entries,
  input  logic [wqg_pkg::ADDR_BITS-1:0]     base_address_low,
  input  logic [wqg_pkg::ADDR_BITS-1:0]     base_address_high,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output wqg_pkg::cmd_t                     cmd
);

  wqg_pkg::cmd_t decoded;
  wqg_pkg::cmd_t hold;
  logic          hold_valid;

  // size zero gives an all-ones mask, same as size minus one
  always_comb begin
    decoded.kind      = wqg_pkg::cmd_kind_t'(opcode);
    decoded.queue     = queue_index;
    decoded.write_ptr = write_pointer;
    decoded.shut      = shut_down;
    decoded.ptr_mask  = wqg_pkg::PTR_BITS'(queue_entries - wqg_pkg::SIZE_BITS'(1));
    decoded.base_lo   = base_address_low;
    decoded.base_hi   = base_address_high;
  end

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= decoded;
    end
  end

endmodule

### rtl/core/wqg_cmd_queue.sv
`timescale 1ns / 1ps
// wqg_cmd_queue: short command queue between front and back
// depends on wqg_pkg

module wqg_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  wqg_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output wqg_pkg::cmd_t pop_cmd
);

  wqg_pkg::cmd_t                       slots [wqg_pkg::CMDQ_DEPTH];
  logic [wqg_pkg::CMDQ_PTR_BITS-1:0]   wr_ptr;
  logic [wqg_pkg::CMDQ_PTR_BITS-1:0]   rd_ptr;
  logic [wqg_pkg::CMDQ_CNT_BITS-1:0]   count;
  logic                                push;
  logic                                pop;

  assign push_ready = count != wqg_pkg::CMDQ_CNT_BITS'(wqg_pkg::CMDQ_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wqg_pkg::CMDQ_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wqg_pkg::CMDQ_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + wqg_pkg::CMDQ_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - wqg_pkg::CMDQ_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/core/wqg_back.sv
`timescale 1ns / 1ps
// wqg_back: descriptor cache, queue pick, batch sizing and dispatch word output
// depends on wqg_pkg

module wqg_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  wqg_pkg::cmd_t                     cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [wqg_pkg::QIDX_BITS-1:0]     picked_queue,
  output logic [wqg_pkg::ADDR_BITS-1:0]     entry_address_low,
  output logic [wqg_pkg::ADDR_BITS-1:0]     entry_address_high,
  output logic [wqg_pkg::OFS_BITS-1:0]      buffer_offset,
  output logic [wqg_pkg::CNT_BITS-1:0]      batch_count,
  output logic                              last
);

  localparam int NQ = wqg_pkg::NUM_QUEUES;
  localparam int QB = wqg_pkg::QIDX_BITS;
  localparam int PB = wqg_pkg::PTR_BITS;
  localparam int AB = wqg_pkg::ADDR_BITS;
  localparam int CB = wqg_pkg::CNT_BITS;

  // descriptor cache
  logic [PB-1:0]  wp_mem      [NQ];
  logic           shut_mem    [NQ];
  logic [PB-1:0]  mask_mem    [NQ];
  logic [AB-1:0]  base_lo_mem [NQ];
  logic [AB-1:0]  base_hi_mem [NQ];
  logic [PB-1:0]  rp_mem      [NQ];
  logic [NQ-1:0]  desc_written;

  logic [NQ-1:0]                   en_mask;
  logic [NQ-1:0]                   snapshot;
  logic [wqg_pkg::SLOT_BITS-1:0]   slot_count;
  wqg_pkg::back_state_t            state;
  wqg_pkg::back_state_t            state_next;

  logic [QB-1:0]                   pick_q;
  logic [PB-1:0]                   run_start;
  logic [AB-1:0]                   run_lo;
  logic [AB-1:0]                   run_hi;
  logic [wqg_pkg::SLOT_BITS-1:0]   run_slot;
  logic [CB-1:0]                   run_num;
  logic [CB-1:0]                   run_idx;

  logic                            out_free;
  logic                            take;
  logic [PB-1:0]                   upd_rp;
  logic                            upd_enable;
  logic [NQ-1:0]                   snap_fill;
  logic [NQ-1:0]                   snap_live;
  logic [NQ-1:0]                   low_bit;
  logic [QB-1:0]                   low_idx;

  logic [PB-1:0]                   calc_rp;
  logic [PB-1:0]                   calc_avail;
  logic [wqg_pkg::ROOM_BITS-1:0]   calc_room;
  logic [CB-1:0]                   calc_num;
  logic                            calc_skip;

  logic [PB:0]                     emit_sum;
  logic [AB-1:0]                   emit_lo;
  logic [wqg_pkg::OFS_BITS-1:0]    emit_ofs;
  logic                            emit_last;

  logic                            out_load;
  wqg_pkg::status_t                nx_status;
  logic [QB-1:0]                   nx_q;
  logic [AB-1:0]                   nx_lo;
  logic [AB-1:0]                   nx_hi;
  logic [wqg_pkg::OFS_BITS-1:0]    nx_ofs;
  logic [CB-1:0]                   nx_cnt;
  logic                            nx_last;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == wqg_pkg::S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;

  // update: queue enable from cached read pointer
  assign upd_rp     = desc_written[cmd.queue] ? rp_mem[cmd.queue] : '0;
  assign upd_enable = !cmd.shut && (cmd.write_ptr != upd_rp);

  // gather: snapshot refill and lowest-bit pick
  assign snap_fill = (snapshot == '0) ? en_mask : snapshot;
  assign snap_live = snap_fill & en_mask;
  assign low_bit   = snap_live & (~snap_live + NQ'(1));

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < NQ; k++) begin
      if (low_bit[k]) begin
        low_idx = low_idx | QB'(k);
      end
    end
  end

  // batch size, clipped at the wrap boundary
  assign calc_rp    = rp_mem[pick_q];
  assign calc_avail = wp_mem[pick_q] - calc_rp;
  assign calc_room  = wqg_pkg::ROOM_BITS'(wqg_pkg::WRAP_SPAN)
                    - wqg_pkg::ROOM_BITS'(calc_rp[wqg_pkg::WRAP_BITS-1:0]);

  always_comb begin
    logic [CB-1:0] want;
    if (calc_avail > PB'(wqg_pkg::BATCH_MAX)) begin
      want = CB'(wqg_pkg::BATCH_MAX);
    end else begin
      want = calc_avail[CB-1:0];
    end
    if (wqg_pkg::ROOM_BITS'(want) > calc_room) begin
      calc_num = calc_room[CB-1:0];
    end else begin
      calc_num = want;
    end
  end

  assign calc_skip = shut_mem[pick_q] || (calc_num == '0);

  assign emit_sum  = {1'b0, run_start} + (PB + 1)'(run_idx);
  assign emit_lo   = run_lo + (AB'(emit_sum) << wqg_pkg::ENTRY_SHIFT);
  assign emit_ofs  = wqg_pkg::OFS_BITS'(run_slot) + wqg_pkg::OFS_BITS'(run_idx);
  assign emit_last = (run_idx + CB'(1)) == run_num;

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    nx_status  = wqg_pkg::ST_DISPATCH;
    nx_q       = '0;
    nx_lo      = '0;
    nx_hi      = '0;
    nx_ofs     = '0;
    nx_cnt     = '0;
    nx_last    = 1'b1;
    unique case (state)
      wqg_pkg::S_IDLE: begin
        if (take) begin
          if (cmd.kind == wqg_pkg::CMD_UPDATE) begin
            out_load  = 1'b1;
            nx_status = wqg_pkg::ST_STORED;
            nx_q      = cmd.queue;
          end else if (snap_live == '0) begin
            out_load  = 1'b1;
            nx_status = wqg_pkg::ST_NO_QUEUE;
          end else begin
            state_next = wqg_pkg::S_CALC;
          end
        end
      end
      wqg_pkg::S_CALC: begin
        if (!calc_skip) begin
          state_next = wqg_pkg::S_EMIT;
        end else if (out_free) begin
          out_load   = 1'b1;
          nx_status  = wqg_pkg::ST_NO_WORK;
          nx_q       = pick_q;
          state_next = wqg_pkg::S_IDLE;
        end
      end
      wqg_pkg::S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          nx_status = wqg_pkg::ST_DISPATCH;
          nx_q      = pick_q;
          nx_lo     = emit_lo;
          nx_hi     = run_hi;
          nx_ofs    = emit_ofs;
          nx_cnt    = run_num;
          nx_last   = emit_last;
          if (emit_last) begin
            state_next = wqg_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = wqg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wqg_pkg::S_IDLE;
      out_valid    <= 1'b0;
      en_mask      <= '0;
      snapshot     <= '0;
      slot_count   <= '0;
      desc_written <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == wqg_pkg::S_IDLE && take) begin
        if (cmd.kind == wqg_pkg::CMD_UPDATE) begin
          desc_written[cmd.queue] <= 1'b1;
          en_mask[cmd.queue]      <= upd_enable;
        end else begin
          snapshot <= snap_live & ~low_bit;
        end
      end
      if (state == wqg_pkg::S_CALC && !calc_skip) begin
        slot_count <= slot_count + wqg_pkg::SLOT_BITS'(calc_num);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status             <= nx_status;
      picked_queue       <= nx_q;
      entry_address_low  <= nx_lo;
      entry_address_high <= nx_hi;
      buffer_offset      <= nx_ofs;
      batch_count        <= nx_cnt;
      last               <= nx_last;
    end
    if (state == wqg_pkg::S_IDLE && take) begin
      if (cmd.kind == wqg_pkg::CMD_UPDATE) begin
        wp_mem[cmd.queue]      <= cmd.write_ptr;
        shut_mem[cmd.queue]    <= cmd.shut;
        mask_mem[cmd.queue]    <= cmd.ptr_mask;
        base_lo_mem[cmd.queue] <= cmd.base_lo;
        base_hi_mem[cmd.queue] <= cmd.base_hi;
        if (!desc_written[cmd.queue]) begin
          rp_mem[cmd.queue] <= '0;
        end
      end else begin
        pick_q <= low_idx;
      end
    end
    if (state == wqg_pkg::S_CALC && !calc_skip) begin
      rp_mem[pick_q] <= calc_rp + PB'(calc_num);
      run_start      <= calc_rp & mask_mem[pick_q];
      run_lo         <= base_lo_mem[pick_q];
      run_hi         <= base_hi_mem[pick_q];
      run_slot       <= slot_count;
      run_num        <= calc_num;
      run_idx        <= '0;
    end
    if (state == wqg_pkg::S_EMIT && out_free) begin
      run_idx <= run_idx + CB'(1);
    end
  end

  a_emit_num: assert property (@(posedge clk) disable iff (rst)
    state == wqg_pkg::S_EMIT |-> run_num != '0 && run_num <= CB'(wqg_pkg::BATCH_MAX))
    else $error("batch size out of range during dispatch");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    state == wqg_pkg::S_EMIT |-> run_idx < run_num)
    else $error("dispatch index past batch size");

  a_pick_enabled: assert property (@(posedge clk) disable iff (rst)
    state == wqg_pkg::S_CALC |-> en_mask[pick_q])
    else $error("picked queue is not enabled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != wqg_pkg::ST_DISPATCH |-> last)
    else $error("non-dispatch word without last");

  a_gather_flow: assert property (@(posedge clk) disable iff (rst)
    take && cmd.kind == wqg_pkg::CMD_GATHER |=>
      state == wqg_pkg::S_CALC || (out_valid && status == wqg_pkg::ST_NO_QUEUE))
    else $error("gather neither picked a queue nor reported none enabled");

endmodule

### rtl/core/work_queue_gather_scheduler_core.sv
`timescale 1ns / 1ps
// work_queue_gather_scheduler_core: top level, front stage, command queue and back end
// a 2-word command queue after the front hold register decouples the input side; the back end
// takes commands only in S_IDLE and loads the output word in S_IDLE (update, empty gather),
// S_CALC (no work) or S_EMIT (up to 4 dispatch words, one word per cycle unless stalled)
// reset: synchronous, clears enables, snapshot, slot counter and descriptor-written marks
// a never-written queue reads with read pointer zero, no clearing pass

module work_queue_gather_scheduler_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [wqg_pkg::QIDX_BITS-1:0]     queue_index,
  input  logic [wqg_pkg::PTR_BITS-1:0]      write_pointer,
  input  logic                              shut_down,
  input  logic [wqg_pkg::SIZE_BITS-1:0]     queue_entries,
  input  logic [wqg_pkg::ADDR_BITS-1:0]     base_address_low,
  input  logic [wqg_pkg::ADDR_BITS-1:0]     base_address_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [wqg_pkg::QIDX_BITS-1:0]     picked_queue,
  output logic [wqg_pkg::ADDR_BITS-1:0]     entry_address_low,
  output logic [wqg_pkg::ADDR_BITS-1:0]     entry_address_high,
  output logic [wqg_pkg::OFS_BITS-1:0]      buffer_offset,
  output logic [wqg_pkg::CNT_BITS-1:0]      batch_count,
  output logic                              last
);

  logic          fr_valid;
  logic          fr_ready;
  wqg_pkg::cmd_t fr_cmd;
  logic          bk_valid;
  logic          bk_ready;
  wqg_pkg::cmd_t bk_cmd;

  wqg_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .queue_index       (queue_index),
    .write_pointer     (write_pointer),
    .shut_down         (shut_down),
    .queue_entries     (queue_entries),
    .base_address_low  (base_address_low),
    .base_address_high (base_address_high),
    .cmd_valid         (fr_valid),
    .cmd_ready         (fr_ready),
    .cmd               (fr_cmd)
  );

  wqg_cmd_queue u_cmd_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  wqg_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (bk_valid),
    .cmd_ready          (bk_ready),
    .cmd                (bk_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .picked_queue       (picked_queue),
    .entry_address_low  (entry_address_low),
    .entry_address_high (entry_address_high),
    .buffer_offset      (buffer_offset),
    .batch_count        (batch_count),
    .last               (last)
  );

endmodule

### tb/work_queue_gather_scheduler_core_tb.sv
`timescale 1ns / 1ps
// work_queue_gather_scheduler_core_tb: self-checking bench for the gather scheduler core
// predicts every dispatch word from descriptor updates and gather steps; needs wqg_pkg and the core

module work_queue_gather_scheduler_core_tb;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ITEMS    = 230;
  localparam int QUIET_ITEMS     = 40;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 16;

  typedef struct packed {
    wqg_pkg::cmd_kind_t                kind;
    logic [wqg_pkg::QIDX_BITS-1:0]     queue;
    logic [wqg_pkg::PTR_BITS-1:0]      wptr;
    logic                              shut;
    logic [wqg_pkg::SIZE_BITS-1:0]     entries;
    logic [wqg_pkg::ADDR_BITS-1:0]     base_lo;
    logic [wqg_pkg::ADDR_BITS-1:0]     base_hi;
  } host_cmd_t;

  typedef struct packed {
    wqg_pkg::status_t                  st;
    logic [wqg_pkg::QIDX_BITS-1:0]     queue;
    logic [wqg_pkg::ADDR_BITS-1:0]     addr_lo;
    logic [wqg_pkg::ADDR_BITS-1:0]     addr_hi;
    logic [wqg_pkg::OFS_BITS-1:0]      offset;
    logic [wqg_pkg::CNT_BITS-1:0]      count;
    logic                              last;
  } dispatch_word_t;

  class dispatch_scoreboard;
    bit [wqg_pkg::PTR_BITS-1:0]    wr_ptr    [wqg_pkg::NUM_QUEUES];
    bit                            shut_flag [wqg_pkg::NUM_QUEUES];
    bit [wqg_pkg::SIZE_BITS-1:0]   entries   [wqg_pkg::NUM_QUEUES];
    bit [wqg_pkg::ADDR_BITS-1:0]   base_lo   [wqg_pkg::NUM_QUEUES];
    bit [wqg_pkg::ADDR_BITS-1:0]   base_hi   [wqg_pkg::NUM_QUEUES];
    bit [wqg_pkg::PTR_BITS-1:0]    rd_ptr    [wqg_pkg::NUM_QUEUES];
    bit [wqg_pkg::NUM_QUEUES-1:0]  enabled;
    bit [wqg_pkg::NUM_QUEUES-1:0]  snapshot;
    bit [wqg_pkg::SLOT_BITS-1:0]   next_slot;
    dispatch_word_t                expected_words[$];
    int errors, n_updates, n_gathers, n_dispatched, n_no_queue, n_no_work;

    function new();
      foreach (wr_ptr[i]) begin
        wr_ptr[i] = '0;
        shut_flag[i] = 1'b0;
        entries[i] = '0;
        base_lo[i] = '0;
        base_hi[i] = '0;
        rd_ptr[i] = '0;
      end
      enabled = '0;
      snapshot = '0;
      next_slot = '0;
      errors = 0;
      n_updates = 0;
      n_gathers = 0;
      n_dispatched = 0;
      n_no_queue = 0;
      n_no_work = 0;
    endfunction

    function void accept_command(host_cmd_t c);
      dispatch_word_t w;
      int unsigned q, rp, num, mask, start, span_mask;
      w = '0;
      w.last = 1'b1;
      span_mask = ~(wqg_pkg::WRAP_SPAN - 1);
      if (c.kind == wqg_pkg::CMD_UPDATE) begin
        q = 32'(c.queue);
        wr_ptr[q] = c.wptr;
        shut_flag[q] = c.shut;
        entries[q] = c.entries;
        base_lo[q] = c.base_lo;
        base_hi[q] = c.base_hi;
        enabled[q] = !c.shut && (c.wptr != rd_ptr[q]);
        w.st = wqg_pkg::ST_STORED;
        w.queue = c.queue;
        expected_words.push_back(w);
        n_updates++;
        return;
      end
      n_gathers++;
      if (snapshot == '0) snapshot = enabled;
      snapshot &= enabled;
      if (snapshot == '0) begin
        w.st = wqg_pkg::ST_NO_QUEUE;
        expected_words.push_back(w);
        n_no_queue++;
        return;
      end
      q = 0;
      while (q < wqg_pkg::NUM_QUEUES - 1 && !snapshot[q]) q++;
      snapshot[q] = 1'b0;
      w.queue = q[wqg_pkg::QIDX_BITS-1:0];
      rp = 32'(rd_ptr[q]);
      num = (wr_ptr[q] - rp) & 32'hFFFF;
      if (num > wqg_pkg::BATCH_MAX) num = wqg_pkg::BATCH_MAX;
      if (((rp + num) & span_mask) != (rp & span_mask))
        num = ((rp + wqg_pkg::WRAP_SPAN) & span_mask) - rp;
      if (shut_flag[q] || num == 0) begin
        w.st = wqg_pkg::ST_NO_WORK;
        expected_words.push_back(w);
        n_no_work++;
        return;
      end
      rd_ptr[q] = wqg_pkg::PTR_BITS'(rp + num);
      mask = (entries[q] == 0) ? 32'hFFFF_FFFF : ((entries[q] - 1) & 32'h1FFFF);
      start = rp & mask;
      for (int unsigned i = 0; i < num; i++) begin
        w.st = wqg_pkg::ST_DISPATCH;
        w.addr_lo = base_lo[q] + (start + i) * 16;
        w.addr_hi = base_hi[q];
        w.offset = wqg_pkg::OFS_BITS'(next_slot + i);
        w.count = num[wqg_pkg::CNT_BITS-1:0];
        w.last = (i + 1 == num);
        expected_words.push_back(w);
      end
      next_slot = wqg_pkg::SLOT_BITS'(next_slot + num);
      n_dispatched += num;
    endfunction

    function void check_dispatch(dispatch_word_t got);
      dispatch_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d queue %0d", got.st, got.queue);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.st !== exp_w.st) begin
        $error("status: expected %0d, got %0d", exp_w.st, got.st);
        errors++;
      end
      if (got.queue !== exp_w.queue) begin
        $error("picked_queue: expected %0d, got %0d", exp_w.queue, got.queue);
        errors++;
      end
      if (got.addr_lo !== exp_w.addr_lo) begin
        $error("entry_address_low: expected %h, got %h", exp_w.addr_lo, got.addr_lo);
        errors++;
      end
      if (got.addr_hi !== exp_w.addr_hi) begin
        $error("entry_address_high: expected %h, got %h", exp_w.addr_hi, got.addr_hi);
        errors++;
      end
      if (got.offset !== exp_w.offset) begin
        $error("buffer_offset: expected %0d, got %0d", exp_w.offset, got.offset);
        errors++;
      end
      if (got.count !== exp_w.count) begin
        $error("batch_count: expected %0d, got %0d", exp_w.count, got.count);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic                               opcode;
  logic [wqg_pkg::QIDX_BITS-1:0]      queue_index;
  logic [wqg_pkg::PTR_BITS-1:0]       write_pointer;
  logic                               shut_down;
  logic [wqg_pkg::SIZE_BITS-1:0]      queue_entries;
  logic [wqg_pkg::ADDR_BITS-1:0]      base_address_low;
  logic [wqg_pkg::ADDR_BITS-1:0]      base_address_high;
  logic                               out_valid;
  logic                               out_ready;
  logic [1:0]                         status;
  logic [wqg_pkg::QIDX_BITS-1:0]      picked_queue;
  logic [wqg_pkg::ADDR_BITS-1:0]      entry_address_low;
  logic [wqg_pkg::ADDR_BITS-1:0]      entry_address_high;
  logic [wqg_pkg::OFS_BITS-1:0]       buffer_offset;
  logic [wqg_pkg::CNT_BITS-1:0]       batch_count;
  logic                               last;

  dispatch_scoreboard sb;
  dispatch_word_t     observed;
  bit                 hold_off_req;
  bit                 quiet_tail;
  int                 cycle_count;
  int                 hot_q[4];

  work_queue_gather_scheduler_core DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .opcode             (opcode),
    .queue_index        (queue_index),
    .write_pointer      (write_pointer),
    .shut_down          (shut_down),
    .queue_entries      (queue_entries),
    .base_address_low   (base_address_low),
    .base_address_high  (base_address_high),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .picked_queue       (picked_queue),
    .entry_address_low  (entry_address_low),
    .entry_address_high (entry_address_high),
    .buffer_offset      (buffer_offset),
    .batch_count        (batch_count),
    .last               (last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed.st = wqg_pkg::status_t'(status);
      observed.queue = picked_queue;
      observed.addr_lo = entry_address_low;
      observed.addr_hi = entry_address_high;
      observed.offset = buffer_offset;
      observed.count = batch_count;
      observed.last = last;
      sb.check_dispatch(observed);
    end
  end

  task automatic send_command(input host_cmd_t c);
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= c.kind;
    queue_index <= c.queue;
    write_pointer <= c.wptr;
    shut_down <= c.shut;
    queue_entries <= c.entries;
    base_address_low <= c.base_lo;
    base_address_high <= c.base_hi;
    do @(posedge clk); while (!in_ready);
    sb.accept_command(c);
  endtask

  task automatic send_update(input int q, input int wp, input bit sd, input int size,
                             input logic [31:0] lo, input logic [31:0] hi);
    host_cmd_t c;
    c.kind = wqg_pkg::CMD_UPDATE;
    c.queue = wqg_pkg::QIDX_BITS'(q);
    c.wptr = wqg_pkg::PTR_BITS'(wp);
    c.shut = sd;
    c.entries = wqg_pkg::SIZE_BITS'(size);
    c.base_lo = lo;
    c.base_hi = hi;
    send_command(c);
  endtask

  task automatic send_gather();
    host_cmd_t c;
    c.kind = wqg_pkg::CMD_GATHER;
    c.queue = wqg_pkg::QIDX_BITS'($urandom);
    c.wptr = wqg_pkg::PTR_BITS'($urandom);
    c.shut = 1'($urandom);
    c.entries = wqg_pkg::SIZE_BITS'($urandom);
    c.base_lo = $urandom;
    c.base_hi = $urandom;
    send_command(c);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 14);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic random_command(output host_cmd_t c);
    int r;
    c.queue = wqg_pkg::QIDX_BITS'($urandom);
    c.wptr = wqg_pkg::PTR_BITS'($urandom);
    c.shut = 1'($urandom);
    c.entries = wqg_pkg::SIZE_BITS'($urandom);
    c.base_lo = $urandom;
    c.base_hi = $urandom;
    if ($urandom_range(0, 99) < 55) begin
      c.kind = wqg_pkg::CMD_GATHER;
      return;
    end
    c.kind = wqg_pkg::CMD_UPDATE;
    if ($urandom_range(0, 3) != 0) c.queue = wqg_pkg::QIDX_BITS'(hot_q[$urandom_range(0, 3)]);
    r = $urandom_range(0, 9);
    if (r == 1) c.wptr = sb.rd_ptr[c.queue];
    else if (r != 0)
      c.wptr = wqg_pkg::PTR_BITS'(sb.rd_ptr[c.queue] + $urandom_range(1, 12));
    c.shut = ($urandom_range(0, 11) == 0);
    r = $urandom_range(0, 9);
    if (r == 0) c.entries = wqg_pkg::SIZE_BITS'($urandom_range(0, 65536));
    else if (r == 1) c.entries = '0;
    else c.entries = wqg_pkg::SIZE_BITS'(1 << $urandom_range(0, 16));
  endtask

  initial begin
    host_cmd_t c;
    sb = new();
    hold_off_req = 1'b0;
    quiet_tail = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = wqg_pkg::CMD_UPDATE;
    queue_index = '0;
    write_pointer = '0;
    shut_down = 1'b0;
    queue_entries = '0;
    base_address_low = '0;
    base_address_high = '0;
    foreach (hot_q[i]) hot_q[i] = $urandom_range(0, wqg_pkg::NUM_QUEUES - 1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty scheduler, address wrap, refill, no work, odd sizes, shutdown
    send_gather();
    send_update(0, 5, 1'b0, 16, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_gather();
    send_gather();
    send_gather();
    send_update(31, 16'hFFFF, 1'b0, 0, 32'h0, 32'h0);
    send_update(7, 9, 1'b0, 6, 32'h1234_5678, 32'h0);
    send_update(3, 7, 1'b1, 65536, 32'hFFFF_FFFF, 32'h8000_0000);
    send_gather();
    send_gather();
    send_gather();
    send_gather();
    send_gather();
    send_gather();
    send_update(0, 100, 1'b1, 65536, 32'h0, 32'h7FFF_FFFF);
    send_gather();
    send_gather();
    send_update(3, 0, 1'b0, 65536, 32'h8000_0000, 32'hFFFF_FFFF);
    send_gather();
    send_gather();
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 80) hold_off_req = 1'b1;
      if (n == 150) wait_drained();
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) sender_gap();
      random_command(c);
      send_command(c);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (sb.expected_words.size() != 0) begin
      $error("%0d expected words never arrived", sb.expected_words.size());
      sb.errors++;
    end
    $display("run: %0d descriptor updates, %0d gather steps, %0d entries dispatched",
             sb.n_updates, sb.n_gathers, sb.n_dispatched);
    $display("run: %0d gathers found nothing enabled, %0d picked a queue with no work",
             sb.n_no_queue, sb.n_no_work);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### work_queue_gather_scheduler_core.f
rtl/core/wqg_pkg.sv
rtl/core/wqg_front.sv
rtl/core/wqg_cmd_queue.sv
rtl/core/wqg_back.sv
rtl/core/work_queue_gather_scheduler_core.sv
tb/work_queue_gather_scheduler_core_tb.sv
